// ===== rtl/velocity_frame_rotation_top_assert.svh =====
// Assertion macros for the velocity frame rotation block.
`ifndef VELOCITY_FRAME_ROTATION_TOP_ASSERT_SVH
`define VELOCITY_FRAME_ROTATION_TOP_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define VFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle requires another in the next cycle.
`define VFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/vfr_pkg.sv =====
// Shared constants and register codes for the velocity frame rotation block.
`default_nettype none

package vfr_pkg;

  localparam int unsigned DEF_SAMPLE_WIDTH   = 16;
  localparam int unsigned DEF_COEF_FRAC_BITS = 14;
  localparam int unsigned COEF_WIDTH         = 16;
  localparam int unsigned CFG_IDX_WIDTH      = 3;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_HEADING_COS = 3'd0,
    REG_HEADING_SIN = 3'd1,
    REG_PITCH_COS   = 3'd2,
    REG_PITCH_SIN   = 3'd3,
    REG_ROLL_COS    = 3'd4,
    REG_ROLL_SIN    = 3'd5
  } vfr_reg_e;

endpackage

`default_nettype wire

// ===== rtl/vfr_sample_if.sv =====
// Input channel carrying one velocity sample per request.
`default_nettype none

interface vfr_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = vfr_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] u_in;
  logic signed [SAMPLE_WIDTH-1:0] v_in;
  logic signed [SAMPLE_WIDTH-1:0] w_in;

  modport source (output valid, output u_in, output v_in, output w_in, input ready);
  modport sink   (input valid, input u_in, input v_in, input w_in, output ready);
endinterface

`default_nettype wire

// ===== rtl/vfr_result_if.sv =====
// Output channel carrying one rotated, saturated velocity sample per request.
`default_nettype none

interface vfr_result_if #(
  parameter int unsigned SAMPLE_WIDTH = vfr_pkg::DEF_SAMPLE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] u_out;
  logic signed [SAMPLE_WIDTH-1:0] v_out;
  logic signed [SAMPLE_WIDTH-1:0] w_out;
  logic                           clipped;

  modport source (output valid, output u_out, output v_out, output w_out, output clipped,
                  input ready);
  modport sink   (input valid, input u_out, input v_out, input w_out, input clipped,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/vfr_rot_cell.sv =====
// One plane rotation cell: product stage, then sum-and-round stage.
`default_nettype none

module vfr_rot_cell #(
  parameter int unsigned IN_W           = 16,
  parameter int unsigned CW             = 16,
  parameter int unsigned COEF_FRAC_BITS = 14,
  localparam int unsigned PW            = IN_W + CW,
  localparam int unsigned OUT_W         = PW + 1 - COEF_FRAC_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [IN_W-1:0]  a_i,
  input  logic signed [IN_W-1:0]  b_i,
  input  logic signed [IN_W-1:0]  carry_i,
  input  logic signed [CW-1:0]    cos_i,
  input  logic signed [CW-1:0]    sin_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [OUT_W-1:0] x_o,
  output logic signed [OUT_W-1:0] y_o,
  output logic signed [IN_W-1:0]  carry_o
);

  localparam logic [PW:0] RND = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);

  logic                   v0_q, v1_q;
  logic                   en0, en1;
  logic signed [PW-1:0]   p_ac_q, p_bs_q, p_bc_q, p_as_q;
  logic signed [PW-1:0]   p_ac_d, p_bs_d, p_bc_d, p_as_d;
  logic signed [IN_W-1:0] c0_q, c1_q;
  logic [PW:0]            sum_x, sum_y;
  logic [PW:0]            rnd_x, rnd_y;
  logic signed [OUT_W-1:0] x_q, y_q;

  assign en1     = !v1_q || ready_i;
  assign en0     = !v0_q || en1;
  assign ready_o = en0;

  assign p_ac_d = a_i * cos_i;
  assign p_bs_d = b_i * sin_i;
  assign p_bc_d = b_i * cos_i;
  assign p_as_d = a_i * sin_i;

  // x = a*c + b*s, y = b*c - a*s, sums kept one bit wider than a product
  assign sum_x = {p_ac_q[PW-1], p_ac_q} + {p_bs_q[PW-1], p_bs_q};
  assign sum_y = {p_bc_q[PW-1], p_bc_q} - {p_as_q[PW-1], p_as_q};
  assign rnd_x = sum_x + RND;
  assign rnd_y = sum_y + RND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) v0_q <= valid_i;
      if (en1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && valid_i) begin
      p_ac_q <= p_ac_d;
      p_bs_q <= p_bs_d;
      p_bc_q <= p_bc_d;
      p_as_q <= p_as_d;
      c0_q   <= carry_i;
    end
    if (en1 && v0_q) begin
      x_q  <= $signed(rnd_x[PW:COEF_FRAC_BITS]);
      y_q  <= $signed(rnd_y[PW:COEF_FRAC_BITS]);
      c1_q <= c0_q;
    end
  end

  assign valid_o = v1_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign carry_o = c1_q;

endmodule

`default_nettype wire

// ===== rtl/vfr_sat_stage.sv =====
// Output register: saturates the three components and flags clipping.
`default_nettype none

module vfr_sat_stage #(
  parameter int unsigned IN_W         = 25,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [IN_W-1:0] u_i,
  input  logic signed [IN_W-1:0] v_i,
  input  logic signed [IN_W-1:0] w_i,
  vfr_result_if.source           result_o
);

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                   vld_q;
  logic                   load;
  logic                   ovf_u, ovf_v, ovf_w;
  logic [SAMPLE_WIDTH-1:0] u_d, v_d, w_d;
  logic [SAMPLE_WIDTH-1:0] u_q, v_q, w_q;
  logic                   clip_q;

  // out of range when the sample's sign bit and the bits above it disagree
  function automatic logic ovf(input logic [IN_W-1:0] x);
    logic [IN_W-SAMPLE_WIDTH:0] top;
    top = x[IN_W-1:SAMPLE_WIDTH-1];
    return !((&top) || !(|top));
  endfunction

  function automatic logic [SAMPLE_WIDTH-1:0] clamp(input logic [IN_W-1:0] x, input logic o);
    logic [SAMPLE_WIDTH-1:0] r;
    if (o) r = x[IN_W-1] ? S_MIN : S_MAX;
    else   r = x[SAMPLE_WIDTH-1:0];
    return r;
  endfunction

  assign ovf_u = ovf(u_i);
  assign ovf_v = ovf(v_i);
  assign ovf_w = ovf(w_i);
  assign u_d   = clamp(u_i, ovf_u);
  assign v_d   = clamp(v_i, ovf_v);
  assign w_d   = clamp(w_i, ovf_w);

  assign ready_o = !vld_q || result_o.ready;
  assign load    = ready_o && valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      u_q    <= u_d;
      v_q    <= v_d;
      w_q    <= w_d;
      clip_q <= ovf_u || ovf_v || ovf_w;
    end
  end

  assign result_o.valid   = vld_q;
  assign result_o.u_out   = $signed(u_q);
  assign result_o.v_out   = $signed(v_q);
  assign result_o.w_out   = $signed(w_q);
  assign result_o.clipped = clip_q;

endmodule

`default_nettype wire

// ===== rtl/velocity_frame_rotation_top.sv =====
// Top level of the three-axis velocity frame rotator.
`default_nettype none

// Rotates each (u, v, w) velocity sample by heading (about z), then pitch
// (about y), then roll (about x), with cosine/sine coefficients in signed
// fixed point having COEF_FRAC_BITS fraction bits (reset values pass samples
// through unchanged). One sample per cycle is accepted unless the chain is
// backpressured; each sample is registered by the product register and the
// sum-and-round register of each of the three rotation cells in turn, then
// by the output register, which saturates the three components and raises
// clipped. A stalled output backpressures the chain one stage at a time, so
// empty stages keep filling. Coefficients must be written through the cfg
// port (index 0..5: heading cos/sin, pitch cos/sin, roll cos/sin; other
// indexes are ignored) only while idle; the block does not enforce this.
module velocity_frame_rotation_top #(
  parameter int unsigned SAMPLE_WIDTH   = vfr_pkg::DEF_SAMPLE_WIDTH,
  parameter int unsigned COEF_FRAC_BITS = vfr_pkg::DEF_COEF_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [vfr_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  logic [vfr_pkg::COEF_WIDTH-1:0]      cfg_wdata_i,
  vfr_sample_if.sink                          sample_i,
  vfr_result_if.source                        result_o
);

  // coefficient registers also hold 1.0 at wide fraction settings
  localparam int unsigned CW = (vfr_pkg::COEF_WIDTH > COEF_FRAC_BITS + 2) ?
                               vfr_pkg::COEF_WIDTH : COEF_FRAC_BITS + 2;
  localparam int unsigned W0 = SAMPLE_WIDTH;
  localparam int unsigned W1 = W0 + CW + 1 - COEF_FRAC_BITS;
  localparam int unsigned W2 = W1 + CW + 1 - COEF_FRAC_BITS;
  localparam int unsigned W3 = W2 + CW + 1 - COEF_FRAC_BITS;
  localparam logic [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  logic signed [CW-1:0] hc_q, hs_q, pc_q, ps_q, rc_q, rs_q;
  logic signed [CW-1:0] wdata_ext;

  assign wdata_ext = CW'($signed(cfg_wdata_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q <= $signed(COEF_ONE);
      hs_q <= '0;
      pc_q <= $signed(COEF_ONE);
      ps_q <= '0;
      rc_q <= $signed(COEF_ONE);
      rs_q <= '0;
    end else if (cfg_we_i) begin
      case (vfr_pkg::vfr_reg_e'(cfg_idx_i))
        vfr_pkg::REG_HEADING_COS: hc_q <= wdata_ext;
        vfr_pkg::REG_HEADING_SIN: hs_q <= wdata_ext;
        vfr_pkg::REG_PITCH_COS:   pc_q <= wdata_ext;
        vfr_pkg::REG_PITCH_SIN:   ps_q <= wdata_ext;
        vfr_pkg::REG_ROLL_COS:    rc_q <= wdata_ext;
        vfr_pkg::REG_ROLL_SIN:    rs_q <= wdata_ext;
        default: ;
      endcase
    end
  end

  // heading cell -> pitch cell
  logic                 h_valid, p_ready;
  logic signed [W1-1:0] u1, v1;
  logic signed [W0-1:0] h_w;
  // pitch cell -> roll cell
  logic                 p_valid, r_ready;
  logic signed [W2-1:0] u2, w2;
  logic signed [W1-1:0] p_v1;
  // roll cell -> output stage
  logic                 r_valid, s_ready;
  logic signed [W3-1:0] v3, w3;
  logic signed [W2-1:0] r_u2;

  vfr_rot_cell #(
    .IN_W(W0), .CW(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sample_i.valid),
    .ready_o (sample_i.ready),
    .a_i     (sample_i.u_in),
    .b_i     (sample_i.v_in),
    .carry_i (sample_i.w_in),
    .cos_i   (hc_q),
    .sin_i   (hs_q),
    .valid_o (h_valid),
    .ready_i (p_ready),
    .x_o     (u1),
    .y_o     (v1),
    .carry_o (h_w)
  );

  vfr_rot_cell #(
    .IN_W(W1), .CW(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h_valid),
    .ready_o (p_ready),
    .a_i     (u1),
    .b_i     (W1'(h_w)),
    .carry_i (v1),
    .cos_i   (pc_q),
    .sin_i   (ps_q),
    .valid_o (p_valid),
    .ready_i (r_ready),
    .x_o     (u2),
    .y_o     (w2),
    .carry_o (p_v1)
  );

  vfr_rot_cell #(
    .IN_W(W2), .CW(CW), .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .ready_o (r_ready),
    .a_i     (W2'(p_v1)),
    .b_i     (w2),
    .carry_i (u2),
    .cos_i   (rc_q),
    .sin_i   (rs_q),
    .valid_o (r_valid),
    .ready_i (s_ready),
    .x_o     (v3),
    .y_o     (w3),
    .carry_o (r_u2)
  );

  vfr_sat_stage #(
    .IN_W(W3), .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (r_valid),
    .ready_o  (s_ready),
    .u_i      (W3'(r_u2)),
    .v_i      (v3),
    .w_i      (w3),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/vfr_checker.sv =====
// Port-level checks for the velocity frame rotation block, bound to the top level.
`default_nettype none

`include "velocity_frame_rotation_top_assert.svh"

module vfr_checker #(
  parameter int unsigned SAMPLE_WIDTH = vfr_pkg::DEF_SAMPLE_WIDTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic signed [SAMPLE_WIDTH-1:0] u_out_i,
  input logic signed [SAMPLE_WIDTH-1:0] v_out_i,
  input logic signed [SAMPLE_WIDTH-1:0] w_out_i,
  input logic                           clipped_i
);

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic u_lim, v_lim, w_lim;

  assign u_lim = (u_out_i == S_MAX) || (u_out_i == S_MIN);
  assign v_lim = (v_out_i == S_MAX) || (v_out_i == S_MIN);
  assign w_lim = (w_out_i == S_MAX) || (w_out_i == S_MIN);

  // a stalled result keeps its request and payload
  `VFR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(u_out_i) && $stable(v_out_i) && $stable(w_out_i)
    && $stable(clipped_i), "result changed while stalled")

  // the chain only refuses input when the output is full and stalled
  `VFR_ASSERT(a_ready_backpressure, !in_ready_i |-> (out_valid_i && !out_ready_i),
    "input refused without output backpressure")

  // a clipped result has at least one component at a sample limit
  `VFR_ASSERT(a_clip_limit, (out_valid_i && clipped_i) |-> (u_lim || v_lim || w_lim),
    "clipped set with no component at a limit")

endmodule

bind velocity_frame_rotation_top vfr_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_vfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .u_out_i     (result_o.u_out),
  .v_out_i     (result_o.v_out),
  .w_out_i     (result_o.w_out),
  .clipped_i   (result_o.clipped)
);

`default_nettype wire
